FILE: hw/rtl/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// Used by the free stack memory, the slot usage memory and the top level.
package fbpa_pkg;

  // Pool geometry
  localparam int unsigned POOL_SLOTS = 64;
  localparam int unsigned SLOT_AW    = $clog2(POOL_SLOTS);
  localparam int unsigned DEPTH_W    = $clog2(POOL_SLOTS + 1);

  // Fixed field widths of the transaction ports
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIVE_W   = 7;

  // Register reset value
  localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = SIZE_W'(256);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOCATED = 2'd3;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Free stack memory access
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic [SLOT_AW-1:0] wr_data;
  } stk_req_t;

  // Slot usage memory access
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic              wr_data;
  } use_req_t;

endpackage

FILE: hw/rtl/fbpa_stack_mem.sv
// Free stack memory: one write port, one registered read port.
// Depends on fbpa_pkg; an entry never written reads as its own index.
module fbpa_stack_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fbpa_pkg::stk_req_t           req_i,
  output logic [fbpa_pkg::SLOT_AW-1:0] rd_data_o
);
  import fbpa_pkg::*;

  logic [SLOT_AW-1:0]    mem_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_q;
  logic [SLOT_AW-1:0]    raw_q;
  logic [SLOT_AW-1:0]    addr_q;
  logic                  vld_rd_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      raw_q  <= mem_q[req_i.rd_addr];
      addr_q <= req_i.rd_addr;
    end
  end

  // Track written entries; reset marks all as holding their index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        vld_rd_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = vld_rd_q ? raw_q : addr_q;

endmodule

FILE: hw/rtl/fbpa_use_mem.sv
// Slot usage memory: one bit per slot, one write port, registered read.
// Depends on fbpa_pkg; an entry never written reads as free.
module fbpa_use_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpa_pkg::use_req_t req_i,
  output logic               rd_data_o
);
  import fbpa_pkg::*;

  logic                  mem_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_q;
  logic                  raw_q;
  logic                  vld_rd_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      raw_q <= mem_q[req_i.rd_addr];
    end
  end

  // Track written entries; reset marks every slot free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        vld_rd_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = vld_rd_q & raw_q;

endmodule

FILE: hw/rtl/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator, top level; uses fbpa_pkg, fbpa_stack_mem, fbpa_use_mem.
// The result is registered: an accepted request is read from the memories, then decided
//   and written back in ST_EXEC, which waits while an earlier result is still unread.
//   No new request is taken until the current one has been written back.
// Reset: asynchronous, active low; all slots free, max size 256, no clearing
//   pass (per-entry valid bits clear at once).
module fixed_block_pool_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fbpa_pkg::SIZE_W-1:0]   cfg_max_block_bytes_i,
  // request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fbpa_pkg::FUNC_W-1:0]   func_i,
  input  logic [fbpa_pkg::SIZE_W-1:0]   request_size_i,
  input  logic [fbpa_pkg::HANDLE_W-1:0] slot_handle_i,
  // result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fbpa_pkg::HANDLE_W-1:0] granted_slot_o,
  output logic [fbpa_pkg::STATUS_W-1:0] status_o,
  output logic [fbpa_pkg::LIVE_W-1:0]   live_count_o
);
  import fbpa_pkg::*;

  state_e               state_q, state_d;
  logic [SIZE_W-1:0]    max_bytes_q;
  logic [FUNC_W-1:0]    func_q;
  logic [SIZE_W-1:0]    size_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [DEPTH_W-1:0]   free_depth_q, free_depth_d;
  logic                 out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0]  granted_q, granted_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [LIVE_W-1:0]    live_q, live_d;

  logic                 in_accept;
  logic                 commit;
  logic [SLOT_AW-1:0]   stk_rd_data;
  logic                 use_rd_data;
  stk_req_t             stk_req;
  use_req_t             use_req;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i & in_ready_o;

  // Memories
  fbpa_stack_mem u_stack_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (stk_req),
    .rd_data_o (stk_rd_data)
  );

  fbpa_use_mem u_use_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (use_req),
    .rd_data_o (use_rd_data)
  );

  // Hold configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_max_block_bytes_i;
    end
  end

  // Capture the request fields of an accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= func_i;
      size_q   <= request_size_i;
      handle_q <= slot_handle_i;
    end
  end

  // Control and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_depth_q <= DEPTH_W'(POOL_SLOTS);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_depth_q <= free_depth_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      granted_q <= granted_d;
      status_q  <= status_d;
      live_q    <= live_d;
    end
  end

  // Sequence: read on accept, decide and write back in ST_EXEC once the output register is free
  always_comb begin
    state_d      = state_q;
    free_depth_d = free_depth_q;
    commit       = 1'b0;
    granted_d    = '0;
    status_d     = STATUS_OK;

    stk_req.rd_en   = in_accept;
    stk_req.rd_addr = SLOT_AW'(free_depth_q - DEPTH_W'(1));
    stk_req.wr_en   = 1'b0;
    stk_req.wr_addr = SLOT_AW'(free_depth_q);
    stk_req.wr_data = SLOT_AW'(handle_q);

    use_req.rd_en   = in_accept;
    use_req.rd_addr = SLOT_AW'(slot_handle_i);
    use_req.wr_en   = 1'b0;
    use_req.wr_addr = SLOT_AW'(handle_q);
    use_req.wr_data = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the output register can take the result
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
          if (func_q == FUNC_ALLOC) begin
            if (size_q > max_bytes_q) begin
              status_d = STATUS_TOO_LARGE;
            end else if (free_depth_q == '0) begin
              status_d = STATUS_EXHAUSTED;
            end else begin
              // pop the top slot and mark it in use
              free_depth_d    = free_depth_q - DEPTH_W'(1);
              granted_d       = HANDLE_W'(stk_rd_data);
              use_req.wr_en   = 1'b1;
              use_req.wr_addr = stk_rd_data;
              use_req.wr_data = 1'b1;
            end
          end else begin
            if (!(32'(handle_q) < 32'(POOL_SLOTS)) || !use_rd_data ||
                (free_depth_q == DEPTH_W'(POOL_SLOTS))) begin
              status_d = STATUS_NOT_ALLOCATED;
            end else begin
              // push the slot back and mark it free
              free_depth_d  = free_depth_q + DEPTH_W'(1);
              stk_req.wr_en = 1'b1;
              use_req.wr_en = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    live_d      = LIVE_W'(DEPTH_W'(POOL_SLOTS) - free_depth_d);
    out_valid_d = commit | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = granted_q;
  assign status_o       = status_q;
  assign live_count_o   = live_q;

`ifndef SYNTH
  // The free stack never holds more entries than the pool has slots
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_depth_q <= DEPTH_W'(POOL_SLOTS))
    else $error("free stack depth beyond pool size");

  // A successful allocate pops exactly one entry
  a_alloc_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && func_q == FUNC_ALLOC && status_d == STATUS_OK) |=>
    free_depth_q == $past(free_depth_q) - DEPTH_W'(1))
    else $error("allocate did not pop the free stack");

  // An accepted transaction always moves the sequencer to ST_EXEC in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_EXEC)
    else $error("accepted transaction not evaluated");

  // Reported live count agrees with the free stack depth after commit
  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> live_count_o == LIVE_W'(DEPTH_W'(POOL_SLOTS) - free_depth_q))
    else $error("live count does not match free stack depth");
`endif

endmodule

FILE: test/fixed_block_pool_allocator_top_tb.sv
// Self-checking testbench for fixed_block_pool_allocator_top: a queue-fed driver and a
// monitor that checks each result against a built-in model of the slot pool.
// Depends on fbpa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_top_tb;
  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } pool_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] slot;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live;
  } pool_res_t;

  // DUT ports
  logic                clk_i                 = 1'b0;
  logic                rst_ni                = 1'b0;
  logic                cfg_valid_i           = 1'b0;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_max_block_bytes_i = '0;
  logic                in_valid_i            = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i                = FUNC_ALLOC;
  logic [SIZE_W-1:0]   request_size_i        = '0;
  logic [HANDLE_W-1:0] slot_handle_i         = '0;
  logic                out_valid_o;
  logic                out_ready_i           = 1'b0;
  logic [HANDLE_W-1:0] granted_slot_o;
  logic [STATUS_W-1:0] status_o;
  logic [LIVE_W-1:0]   live_count_o;

  // Pool model state
  logic [SLOT_AW-1:0]    free_stack_m [POOL_SLOTS];
  int unsigned           free_depth_m;
  logic [POOL_SLOTS-1:0] slot_busy_m;
  logic [SIZE_W-1:0]     max_bytes_m;

  // Stimulus and checking
  pool_req_t   pending_ops_q [$];
  pool_res_t   expected_res_q [$];
  pool_req_t   next_op;
  pool_res_t   want_res;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  fixed_block_pool_allocator_top i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_max_block_bytes_i (cfg_max_block_bytes_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .func_i                (func_i),
    .request_size_i        (request_size_i),
    .slot_handle_i         (slot_handle_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .granted_slot_o        (granted_slot_o),
    .status_o              (status_o),
    .live_count_o          (live_count_o)
  );

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one operation to the pool model and return the result it should produce
  function automatic pool_res_t apply_pool_op(input pool_req_t op);
    pool_res_t   res;
    int unsigned slot;
    res = '0;
    if (op.func == FUNC_ALLOC) begin
      if (op.size > max_bytes_m) begin
        res.status = STATUS_TOO_LARGE;
      end else if (free_depth_m == 0) begin
        res.status = STATUS_EXHAUSTED;
      end else begin
        free_depth_m--;
        slot = free_stack_m[free_depth_m];
        slot_busy_m[slot] = 1'b1;
        res.slot   = HANDLE_W'(slot);
        res.status = STATUS_OK;
      end
    end else begin
      // double free, or a push onto a full stack: flag and ignore
      if (!slot_busy_m[op.handle] || free_depth_m >= POOL_SLOTS) begin
        res.status = STATUS_NOT_ALLOCATED;
      end else begin
        slot_busy_m[op.handle] = 1'b0;
        free_stack_m[free_depth_m] = op.handle;
        free_depth_m++;
        res.status = STATUS_OK;
      end
    end
    res.live = LIVE_W'(POOL_SLOTS - free_depth_m);
    return res;
  endfunction

  // Driver: hold each transaction until accepted, then advance from the queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      func_i         <= FUNC_ALLOC;
      request_size_i <= '0;
      slot_handle_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_ops_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_op = pending_ops_q.pop_front();
        in_valid_i     <= 1'b1;
        func_i         <= next_op.func;
        request_size_i <= next_op.size;
        slot_handle_i  <= next_op.handle;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check results first, then predict for newly accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        free_stack_m[i] = SLOT_AW'(i);
      end
      free_depth_m = POOL_SLOTS;
      slot_busy_m  = '0;
      max_bytes_m  = MAX_BYTES_RESET;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_res_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result slot=%0d status=%0d live=%0d",
                                    granted_slot_o, status_o, live_count_o));
        end else begin
          want_res = expected_res_q.pop_front();
          if (granted_slot_o !== want_res.slot)
            report_mismatch($sformatf("granted_slot got %0d want %0d",
                                      granted_slot_o, want_res.slot));
          if (status_o !== want_res.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want_res.status));
          if (live_count_o !== want_res.live)
            report_mismatch($sformatf("live_count got %0d want %0d",
                                      live_count_o, want_res.live));
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_res_q.push_back(apply_pool_op('{func_i, request_size_i, slot_handle_i}));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_bytes_m = cfg_max_block_bytes_i;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fixed_block_pool_allocator_top_tb: done, errors");
      $finish;
    end
  end

  task automatic push_alloc(input int unsigned size);
    pending_ops_q.push_back('{FUNC_ALLOC, SIZE_W'(size), HANDLE_W'(0)});
  endtask

  task automatic push_release(input int unsigned handle);
    pending_ops_q.push_back('{FUNC_RELEASE, SIZE_W'($urandom_range(0, 65535)),
                              HANDLE_W'(handle)});
  endtask

  // Wait until no transaction is queued, in flight or owed a result
  task automatic wait_idle();
    while (pending_ops_q.size() != 0 || in_valid_i || expected_res_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Write the size limit while the pool is idle
  task automatic write_max_bytes(input int unsigned value);
    @(posedge clk_i);
    cfg_valid_i           <= 1'b1;
    cfg_max_block_bytes_i <= SIZE_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Request sizes clustered around the current limit
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, max_bytes_m);
    if (r < 45) return max_bytes_m;
    if (r < 55) return (max_bytes_m == 16'hFFFF) ? 65535 : max_bytes_m + 1;
    if (r < 75) return $urandom_range(0, 65535);
    if (r < 85) return 0;
    return 65535;
  endfunction

  // Mostly slots currently held, otherwise any slot
  function automatic int unsigned pick_handle();
    int unsigned start;
    start = $urandom_range(0, POOL_SLOTS - 1);
    if (slot_busy_m != '0 && $urandom_range(0, 99) < 75) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (slot_busy_m[(start + i) % POOL_SLOTS]) return (start + i) % POOL_SLOTS;
      end
    end
    return start;
  endfunction

  // Random traffic in fill and drain bursts so the pool runs full and empty
  task automatic run_random(input int unsigned count, input bit mid_pause);
    int unsigned burst_left;
    int unsigned alloc_pct;
    burst_left = 0;
    alloc_pct  = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 90);
        alloc_pct  = $urandom_range(0, 1) ? 85 : 15;
      end
      burst_left--;
      // hold the sender until every result is back
      if (mid_pause && i == count / 2) wait_idle();
      while (pending_ops_q.size() >= 2) @(negedge clk_i);
      if ($urandom_range(0, 99) < alloc_pct) push_alloc(pick_size());
      else push_release(pick_handle());
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 18;
    recv_stall_pct = 87;

    // Directed: size edges at the reset limit, LIFO reuse, double free, end slots
    push_alloc(0);
    push_alloc(256);
    push_alloc(257);
    push_alloc(65535);
    push_release(62);
    push_release(62);
    push_alloc(1);
    push_release(0);
    push_release(63);
    push_release(62);
    push_release(63);
    push_alloc(255);
    push_release(63);
    push_release(1);
    wait_idle();

    // Zero limit: only empty requests fit
    write_max_bytes(0);
    push_alloc(0);
    push_alloc(1);
    push_release(63);
    run_random(150, 1'b0);
    wait_idle();

    send_idle_pct  = 87;
    recv_stall_pct = 18;
    write_max_bytes(65535);
    push_alloc(65535);
    run_random(350, 1'b0);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_max_bytes($urandom_range(1, 65534));
    run_random(350, 1'b1);
    wait_idle();

    write_max_bytes(MAX_BYTES_RESET);
    run_random(330, 1'b0);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_res_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_res_q.size()));
    if (mismatch_count == 0) begin
      $display("fixed_block_pool_allocator_top_tb: done, clean");
    end else begin
      $display("fixed_block_pool_allocator_top_tb: done, errors");
    end
    $finish;
  end

endmodule
